@@ src/superfast_hash_stream_defines.svh @@
// Assertion macros used by the checker of the hash stream block.
`ifndef SUPERFAST_HASH_STREAM_DEFINES_SVH
`define SUPERFAST_HASH_STREAM_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define SHS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("shs assertion failed");

// Concurrent assertion that is also checked during reset.
`define SHS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("shs assertion failed during or after reset");

`endif

@@ src/shs_pkg.sv @@
// Package with the types and mixing functions of the hash stream block.
package shs_pkg;

   // State snapshot handed to the finishing pipeline on a last beat.
   typedef struct packed {
      logic [31:0] hash;
      logic [23:0] bytes;
      logic [1:0]  count;
   } fin_type;

   localparam logic [1:0] CNT_NONE  = 2'd0;
   localparam logic [1:0] CNT_ONE   = 2'd1;
   localparam logic [1:0] CNT_TWO   = 2'd2;
   localparam logic [1:0] CNT_THREE = 2'd3;

   // One round over a full group, halves read little-endian.
   function automatic logic [31:0] mix_group(input logic [31:0] h_i,
                                             input logic [15:0] lo_i,
                                             input logic [15:0] hi_i);
      logic [31:0] h;
      logic [31:0] t;
      h = h_i + {16'd0, lo_i};
      t = {5'd0, hi_i, 11'd0} ^ h;
      h = {h[15:0], 16'd0} ^ t;
      h = h + {11'd0, h[31:11]};
      return h;
   endfunction

   // Mix of the one to three bytes left over at the end of a message.
   function automatic logic [31:0] tail_mix(input logic [31:0] h_i,
                                            input logic [23:0] bytes_i,
                                            input logic [1:0]  count_i);
      logic [31:0] h;
      h = h_i;
      unique case (count_i)
         CNT_ONE: begin
            h = h + {24'd0, bytes_i[7:0]};
            h = h ^ {h[21:0], 10'd0};
            h = h + {1'b0, h[31:1]};
         end
         CNT_TWO: begin
            h = h + {16'd0, bytes_i[15:0]};
            h = h ^ {h[20:0], 11'd0};
            h = h + {17'd0, h[31:17]};
         end
         CNT_THREE: begin
            h = h + {16'd0, bytes_i[15:0]};
            h = h ^ {h[15:0], 16'd0};
            h = h ^ {6'd0, bytes_i[23:16], 18'd0};
            h = h + {11'd0, h[31:11]};
         end
         default: begin
            h = h_i;
         end
      endcase
      return h;
   endfunction

   // First half of the avalanche.
   function automatic logic [31:0] aval_a(input logic [31:0] h_i);
      logic [31:0] h;
      h = h_i ^ {h_i[28:0], 3'd0};
      h = h + {5'd0, h[31:5]};
      h = h ^ {h[27:0], 4'd0};
      return h;
   endfunction

   // Second half of the avalanche.
   function automatic logic [31:0] aval_b(input logic [31:0] h_i);
      logic [31:0] h;
      h = h_i + {17'd0, h_i[31:17]};
      h = h ^ {h[6:0], 25'd0};
      h = h + {6'd0, h[31:6]};
      return h;
   endfunction

endpackage

@@ src/shs_finish.sv @@
// Finishing pipeline: tail mix, avalanche and the result register.
module shs_finish (
   input  logic             clock,
   input  logic             reset,
   input  logic             fin_valid,
   input  shs_pkg::fin_type fin_data,
   output logic             fin_ready,
   output logic             rsp_valid,
   output logic [31:0]      rsp_hash_value,
   input  logic             rsp_stall
);
   import shs_pkg::*;

   logic        v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, vo_ff, vo_in;
   fin_type     s1_ff, s1_in;
   logic [31:0] s2_ff, s2_in, s3_ff, s3_in, so_ff, so_in;
   logic        adv_out, rdy3, rdy2, rdy1;

   // Each stage takes a new beat when it is empty or its beat moves on.
   assign adv_out   = !vo_ff || !rsp_stall;
   assign rdy3      = !v3_ff || adv_out;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign fin_ready = rdy1;

   // Next valid bits and payloads of the four stages.
   always_comb begin
      v1_in = rdy1    ? fin_valid : v1_ff;
      v2_in = rdy2    ? v1_ff     : v2_ff;
      v3_in = rdy3    ? v2_ff     : v3_ff;
      vo_in = adv_out ? v3_ff     : vo_ff;
      s1_in = (rdy1 && fin_valid) ? fin_data : s1_ff;
      s2_in = (rdy2 && v1_ff) ? tail_mix(s1_ff.hash, s1_ff.bytes, s1_ff.count) : s2_ff;
      s3_in = (rdy3 && v2_ff) ? aval_a(s2_ff) : s3_ff;
      so_in = (adv_out && v3_ff) ? aval_b(s3_ff) : so_ff;
   end

   // Valid bits clear on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         vo_ff <= vo_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      so_ff <= so_in;
   end

   assign rsp_valid      = vo_ff;
   assign rsp_hash_value = so_ff;

endmodule

@@ src/superfast_hash_stream.sv @@
// Top level of the streaming 32-bit SuperFastHash block.
// A last beat passes the input register, then s1, s2, s3 and so, to reach the rsp port.
// Throughput: one beat per cycle unless stalled; the running hash round is a single stage.
// The finishing pipeline holds up to four messages, so stalls propagate back to req_stall.
// Reset (synchronous) clears the running hash, gathered bytes and all valid bits.
module superfast_hash_stream (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_last_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value
);
   import shs_pkg::*;

   logic        v0_ff, v0_in;
   logic [7:0]  byte_ff, byte_in;
   logic        present_ff, present_in;
   logic        last_ff, last_in;
   logic [31:0] hash_ff, hash_in;
   logic [23:0] bytes_ff, bytes_in;
   logic [1:0]  count_ff, count_in;
   logic [31:0] hash_upd;
   logic [23:0] bytes_upd;
   logic [1:0]  count_upd;
   logic        go0;
   logic        fin_ready;
   fin_type     fin_data;

   // The input beat leaves when it ends no message or the finisher can take it.
   assign go0       = v0_ff && (!last_ff || fin_ready);
   assign req_stall = v0_ff && !go0;

   // Input register.
   always_comb begin
      v0_in      = req_stall ? v0_ff : req_valid;
      byte_in    = byte_ff;
      present_in = present_ff;
      last_in    = last_ff;
      if (req_valid && !req_stall) begin
         byte_in    = req_data_byte;
         present_in = req_byte_present;
         last_in    = req_last_item;
      end
   end

   // Gather a byte, or mix the full group when it is the fourth one.
   always_comb begin
      hash_upd  = hash_ff;
      bytes_upd = bytes_ff;
      count_upd = count_ff;
      if (present_ff) begin
         unique case (count_ff)
            CNT_NONE: begin
               bytes_upd[7:0] = byte_ff;
               count_upd      = CNT_ONE;
            end
            CNT_ONE: begin
               bytes_upd[15:8] = byte_ff;
               count_upd       = CNT_TWO;
            end
            CNT_TWO: begin
               bytes_upd[23:16] = byte_ff;
               count_upd        = CNT_THREE;
            end
            default: begin
               hash_upd  = mix_group(hash_ff, bytes_ff[15:0], {byte_ff, bytes_ff[23:16]});
               bytes_upd = '0;
               count_upd = CNT_NONE;
            end
         endcase
      end
   end

   // Commit the update; a last beat hands the state over and starts afresh.
   always_comb begin
      hash_in  = hash_ff;
      bytes_in = bytes_ff;
      count_in = count_ff;
      if (go0) begin
         if (last_ff) begin
            hash_in  = '0;
            bytes_in = '0;
            count_in = CNT_NONE;
         end else begin
            hash_in  = hash_upd;
            bytes_in = bytes_upd;
            count_in = count_upd;
         end
      end
   end

   assign fin_data.hash  = hash_upd;
   assign fin_data.bytes = bytes_upd;
   assign fin_data.count = count_upd;

   // Control state and running hash.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff    <= 1'b0;
         hash_ff  <= '0;
         bytes_ff <= '0;
         count_ff <= CNT_NONE;
      end else begin
         v0_ff    <= v0_in;
         hash_ff  <= hash_in;
         bytes_ff <= bytes_in;
         count_ff <= count_in;
      end
   end

   // Input payload register.
   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      present_ff <= present_in;
      last_ff    <= last_in;
   end

   shs_finish u_finish (
      .clock          (clock),
      .reset          (reset),
      .fin_valid      (v0_ff && last_ff),
      .fin_data       (fin_data),
      .fin_ready      (fin_ready),
      .rsp_valid      (rsp_valid),
      .rsp_hash_value (rsp_hash_value),
      .rsp_stall      (rsp_stall)
   );

endmodule

@@ src/shs_checker.sv @@
// Port-level checker for the hash stream block and its bind.
`include "superfast_hash_stream_defines.svh"

module shs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last_item,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_hash_value
);

   logic [2:0] pend_ff, pend_in;
   logic       acc_last, deliver;

   // Count messages whose last beat is in but whose hash is not yet taken.
   assign acc_last = req_valid && !req_stall && req_last_item;
   assign deliver  = rsp_valid && !rsp_stall;

   always_comb begin
      pend_in = pend_ff;
      if (acc_last && !deliver) begin
         pend_in = pend_ff + 3'd1;
      end else if (!acc_last && deliver) begin
         pend_in = pend_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // No result is left over after a reset.
   `SHS_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid)
   // A hash only shows for a message whose last beat has been taken.
   `SHS_ASSERT(a_no_invented, clock, reset, rsp_valid |-> pend_ff != 3'd0)
   // The block never holds more messages than its five stages.
   `SHS_ASSERT(a_capacity, clock, reset, pend_ff <= 3'd5)
   // A stalled hash holds.
   `SHS_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hash_value))

endmodule

bind superfast_hash_stream shs_checker u_shs_checker (.*);
